[hdl/rrdme_pkg.sv]
// Shared types and constants for the run-length rank expander.
package rrdme_pkg;

	localparam int CFG_W = 17;
	localparam int REG_IDX_W = 2;
	localparam int ADDR_W = 10;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int OFF_W = 27;
	localparam int MEM_W = 1 + 16 + OFF_W;

	localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PRED_COUNT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DENSE_THRESHOLD = 2'd2;

	localparam logic [6:0] MAX_CHUNK = 7'd64;
	localparam logic [10:0] MAX_PREDS = 11'd1024;

	localparam logic OP_SURVEY = 1'b0;
	localparam logic OP_EXPAND = 1'b1;
	localparam logic KIND_DESC = 1'b0;
	localparam logic KIND_ELEM = 1'b1;

	typedef struct packed {
		logic load;
		logic prep;
		logic check;
		logic surv;
		logic desc;
		logic mul;
		logic base;
		logic decide;
		logic emit;
		logic fin;
	} rrdme_cmd_t;

	typedef struct packed {
		logic in_range;
		logic op;
		logic first;
		logic skip;
		logic last_elem;
	} rrdme_stat_t;

endpackage

[hdl/rrdme_ctrl.sv]
// Controller state machine that sequences one item through the datapath.
module rrdme_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rrdme_pkg::rrdme_stat_t stat,
	output rrdme_pkg::rrdme_cmd_t  cmd,
	output logic                 busy
);
	import rrdme_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PREP   = 4'd1;
	localparam logic [3:0] S_CHECK  = 4'd2;
	localparam logic [3:0] S_SURV   = 4'd3;
	localparam logic [3:0] S_DESC   = 4'd4;
	localparam logic [3:0] S_MEM    = 4'd5;
	localparam logic [3:0] S_BASE   = 4'd6;
	localparam logic [3:0] S_DECIDE = 4'd7;
	localparam logic [3:0] S_EMIT   = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_PREP;
			end
			S_PREP: state_d = S_CHECK;
			S_CHECK: begin
				if (!stat.in_range) state_d = S_IDLE;
				else if (stat.op == OP_SURVEY) state_d = S_SURV;
				else state_d = S_MEM;
			end
			S_SURV: state_d = S_DESC;
			S_DESC: state_d = S_IDLE;
			S_MEM: begin
				if (stat.first) state_d = S_BASE;
				else state_d = S_DECIDE;
			end
			S_BASE: state_d = S_DECIDE;
			S_DECIDE: begin
				if (stat.skip) state_d = S_FIN;
				else state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.last_elem) state_d = S_FIN;
			end
			S_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.prep   = (state_q == S_PREP);
		cmd.check  = (state_q == S_CHECK);
		cmd.surv   = (state_q == S_SURV);
		cmd.desc   = (state_q == S_DESC);
		cmd.mul    = (state_q == S_MEM);
		cmd.base   = (state_q == S_BASE);
		cmd.decide = (state_q == S_DECIDE);
		cmd.emit   = (state_q == S_EMIT);
		cmd.fin    = (state_q == S_FIN);
	end

endmodule

[hdl/rrdme_dp.sv]
// Datapath: configuration, column counters, per-column memory and result formatting.
module rrdme_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [rrdme_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [rrdme_pkg::CFG_W-1:0]         wr_data,
	input  logic                                operation,
	input  logic [15:0]                         start_row,
	input  logic [15:0]                         rank,
	input  logic [6:0]                          run_length,
	input  rrdme_pkg::rrdme_cmd_t               cmd,
	output rrdme_pkg::rrdme_stat_t              stat,
	output logic                                strobe,
	output logic                                kind,
	output logic [9:0]                          predictor,
	output logic [15:0]                         row_out,
	output logic [15:0]                         rank_out,
	output logic [25:0]                         out_index,
	output logic                                is_dense,
	output logic [16:0]                         explicit_count,
	output logic                                last
);
	import rrdme_pkg::*;

	logic [16:0] row_count_q;
	logic [10:0] pred_count_q;
	logic [16:0] threshold_q;

	logic        op_q;
	logic [15:0] srow_q;
	logic [15:0] rank_q;
	logic [6:0]  raw_len_q;
	logic [6:0]  len_q;

	logic        expanding_q;
	logic [10:0] cur_pred_q;
	logic [16:0] rows_seen_q;
	logic [16:0] run_total_q;
	logic [16:0] best_run_q;
	logic [15:0] best_rank_q;
	logic [15:0] prev_rank_q;
	logic        first_q;
	logic [10:0] sparse_q;
	logic [26:0] packed_q;
	logic [26:0] write_idx_q;
	logic [5:0]  elem_q;
	logic [26:0] prod_q;

	logic [MEM_W-1:0] col_mem [MEM_DEPTH];
	logic [MEM_W-1:0] rd_q;
	logic             mem_dense;
	logic [15:0]      mem_rank;
	logic [OFF_W-1:0] mem_off;

	logic [10:0] active;
	logic [6:0]  clip_len;
	logic [16:0] rem;
	logic [6:0]  eff_len;
	logic [16:0] new_run;
	logic        col_done;
	logic        dense;
	logic [16:0] cnt;
	logic [26:0] mul_a;
	logic [43:0] mul_full;
	logic [16:0] fin_rows;
	logic        mem_we;
	logic [MEM_W-1:0] mem_wdata;

	assign active   = (pred_count_q < MAX_PREDS) ? pred_count_q : MAX_PREDS;
	assign clip_len = (raw_len_q > MAX_CHUNK) ? MAX_CHUNK : raw_len_q;
	assign rem      = (rows_seen_q < row_count_q) ? (row_count_q - rows_seen_q) : 17'd0;
	assign eff_len  = ({10'd0, clip_len} > rem) ? rem[6:0] : clip_len;
	assign new_run  = (!first_q && (rank_q == prev_rank_q)) ?
		(run_total_q + {10'd0, len_q}) : {10'd0, len_q};
	assign col_done = (rows_seen_q >= row_count_q);
	assign dense    = (best_run_q > threshold_q);
	assign cnt      = dense ? (row_count_q - best_run_q) : row_count_q;
	assign fin_rows = rows_seen_q + {10'd0, len_q};

	assign mem_dense = rd_q[MEM_W-1];
	assign mem_rank  = rd_q[MEM_W-2 -: 16];
	assign mem_off   = rd_q[OFF_W-1:0];
	assign mul_a     = mem_dense ? {16'd0, sparse_q} : mem_off;
	assign mul_full  = mul_a * row_count_q;

	assign mem_we    = cmd.desc && col_done;
	assign mem_wdata = {dense, (dense ? best_rank_q : 16'd0),
		(dense ? packed_q : {16'd0, sparse_q})};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= 17'd1;
			pred_count_q <= 11'd1;
			threshold_q  <= 17'd65536;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROW_COUNT:       row_count_q  <= wr_data;
				REG_PRED_COUNT:      pred_count_q <= wr_data[10:0];
				REG_DENSE_THRESHOLD: threshold_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= operation;
			srow_q    <= start_row;
			rank_q    <= rank;
			raw_len_q <= run_length;
		end
		if (cmd.check) len_q <= eff_len;
		if (cmd.mul) prod_q <= mul_full[26:0];
		if (mem_we) col_mem[cur_pred_q[ADDR_W-1:0]] <= mem_wdata;
		rd_q <= col_mem[cur_pred_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expanding_q <= 1'b0;
			cur_pred_q  <= '0;
			rows_seen_q <= '0;
			run_total_q <= '0;
			best_run_q  <= '0;
			best_rank_q <= '0;
			prev_rank_q <= '0;
			first_q     <= 1'b1;
			sparse_q    <= '0;
			packed_q    <= '0;
			write_idx_q <= '0;
			elem_q      <= '0;
		end else begin
			if (cmd.prep) begin
				if ((op_q == OP_SURVEY) && expanding_q) begin
					expanding_q <= 1'b0;
					cur_pred_q  <= '0;
					sparse_q    <= '0;
					packed_q    <= '0;
					write_idx_q <= '0;
					rows_seen_q <= '0;
					run_total_q <= '0;
					best_run_q  <= '0;
					best_rank_q <= '0;
					prev_rank_q <= '0;
					first_q     <= 1'b1;
				end else if ((op_q == OP_EXPAND) && !expanding_q) begin
					expanding_q <= 1'b1;
					cur_pred_q  <= '0;
					rows_seen_q <= '0;
					run_total_q <= '0;
					best_run_q  <= '0;
					best_rank_q <= '0;
					prev_rank_q <= '0;
					first_q     <= 1'b1;
				end
			end
			if (cmd.surv && (len_q != 7'd0)) begin
				run_total_q <= new_run;
				prev_rank_q <= rank_q;
				first_q     <= 1'b0;
				rows_seen_q <= fin_rows;
				if (new_run > best_run_q) begin
					best_run_q  <= new_run;
					best_rank_q <= rank_q;
				end
			end
			if (cmd.desc && col_done) begin
				if (dense) packed_q <= packed_q + {10'd0, row_count_q} - {10'd0, best_run_q};
				else sparse_q <= sparse_q + 11'd1;
				cur_pred_q  <= cur_pred_q + 11'd1;
				rows_seen_q <= '0;
				run_total_q <= '0;
				best_run_q  <= '0;
				best_rank_q <= '0;
				prev_rank_q <= '0;
				first_q     <= 1'b1;
			end
			if (cmd.base) begin
				write_idx_q <= mem_dense ? (mem_off + prod_q) : prod_q;
				first_q     <= 1'b0;
			end
			if (cmd.decide) elem_q <= '0;
			if (cmd.emit) begin
				write_idx_q <= write_idx_q + 27'd1;
				elem_q      <= elem_q + 6'd1;
			end
			if (cmd.fin) begin
				if (fin_rows >= row_count_q) begin
					cur_pred_q  <= cur_pred_q + 11'd1;
					rows_seen_q <= '0;
					run_total_q <= '0;
					best_run_q  <= '0;
					best_rank_q <= '0;
					prev_rank_q <= '0;
					first_q     <= 1'b1;
				end else begin
					rows_seen_q <= fin_rows;
				end
			end
		end
	end

	always_comb begin
		stat.in_range  = (cur_pred_q < active);
		stat.op        = op_q;
		stat.first     = first_q;
		stat.skip      = (len_q == 7'd0) || (mem_dense && (rank_q == mem_rank));
		stat.last_elem = ({1'b0, elem_q} == (len_q - 7'd1));
	end

	always_comb begin
		strobe    = cmd.emit || (cmd.desc && col_done);
		predictor = cur_pred_q[9:0];
		if (cmd.emit) begin
			kind           = KIND_ELEM;
			row_out        = srow_q + {10'd0, elem_q};
			rank_out       = rank_q;
			out_index      = write_idx_q[25:0];
			is_dense       = 1'b0;
			explicit_count = '0;
			last           = stat.last_elem;
		end else begin
			kind           = KIND_DESC;
			row_out        = '0;
			rank_out       = dense ? best_rank_q : 16'd0;
			out_index      = '0;
			is_dense       = dense;
			explicit_count = cnt;
			last           = 1'b1;
		end
	end

endmodule

[hdl/rle_rank_dense_mode_expander.sv]
// Top level of the two-pass run-length rank expander.
// Each item takes one operation at a time and the block stays busy until it is done. A survey item
// passes through the prep, check, survey and descriptor states and gives at most one descriptor.
// An expand item passes through prep, check and the memory read, then decide, an emit step for
// each element it emits (up to 64) and fin; the first item of a column also passes a base state
// to form the column's base index through the offset multiplier. An item that arrives after every
// column of its pass is done leaves after the check and gives nothing. Results appear for one cycle
// each on strobe and cannot be held off by the receiver. Per-column state lives in a 1024-entry
// memory with a registered read, which the expand pass reads at the current column.
module rle_rank_dense_mode_expander (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [rrdme_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [rrdme_pkg::CFG_W-1:0]     wr_data,
	input  logic                            start,
	output logic                            busy,
	input  logic                            operation,
	input  logic [15:0]                     start_row,
	input  logic [15:0]                     rank,
	input  logic [6:0]                      run_length,
	output logic                            strobe,
	output logic                            kind,
	output logic [9:0]                      predictor,
	output logic [15:0]                     row_out,
	output logic [15:0]                     rank_out,
	output logic [25:0]                     out_index,
	output logic                            is_dense,
	output logic [16:0]                     explicit_count,
	output logic                            last
);
	import rrdme_pkg::*;

	rrdme_cmd_t  cmd;
	rrdme_stat_t stat;

	rrdme_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rrdme_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.operation      (operation),
		.start_row      (start_row),
		.rank           (rank),
		.run_length     (run_length),
		.cmd            (cmd),
		.stat           (stat),
		.strobe         (strobe),
		.kind           (kind),
		.predictor      (predictor),
		.row_out        (row_out),
		.rank_out       (rank_out),
		.out_index      (out_index),
		.is_dense       (is_dense),
		.explicit_count (explicit_count),
		.last           (last)
	);

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the two-pass run-length rank expander.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rrdme_pkg::*;

	typedef struct packed {
		logic        op;
		logic [15:0] srow;
		logic [15:0] rk;
		logic [6:0]  len;
	} entry_t;

	typedef struct packed {
		logic        kind;
		logic [9:0]  col;
		logic [15:0] row;
		logic [15:0] rnk;
		logic [25:0] idx;
		logic        dense;
		logic [16:0] cnt;
		logic        fin;
	} rec_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;
	logic                 start;
	logic                 busy;
	logic                 operation;
	logic [15:0]          start_row;
	logic [15:0]          rank;
	logic [6:0]           run_length;
	logic                 strobe;
	logic                 kind;
	logic [9:0]           predictor;
	logic [15:0]          row_out;
	logic [15:0]          rank_out;
	logic [25:0]          out_index;
	logic                 is_dense;
	logic [16:0]          explicit_count;
	logic                 last;

	rle_rank_dense_mode_expander i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.start(start),
		.busy(busy),
		.operation(operation),
		.start_row(start_row),
		.rank(rank),
		.run_length(run_length),
		.strobe(strobe),
		.kind(kind),
		.predictor(predictor),
		.row_out(row_out),
		.rank_out(rank_out),
		.out_index(out_index),
		.is_dense(is_dense),
		.explicit_count(explicit_count),
		.last(last)
	);

	entry_t      runs_to_send[$];
	rec_t        records_due[$];
	int unsigned fault_count = 0;
	int unsigned entries_queued = 0;
	int unsigned random_sent = 0;

	int unsigned cfg_rows;
	int unsigned cfg_preds;
	logic [16:0] cfg_thresh;

	logic [10:0] col;
	int unsigned rows_done;
	logic [16:0] cur_run;
	logic [16:0] long_run;
	logic [15:0] long_rank;
	logic [15:0] prev_rank;
	bit          fresh;
	bit          expanding;
	logic [10:0] sparse_cnt;
	logic [26:0] packed_sum;
	logic [26:0] wr_idx;
	bit          dense_mem [MEM_DEPTH];
	bit   [15:0] dom_mem [MEM_DEPTH];
	bit   [26:0] off_mem [MEM_DEPTH];

	logic        took = 1'b0;
	int unsigned gap_left = 0;
	bit          fast_mode = 1'b0;
	bit          keep_start;
	entry_t      cur;

	function automatic void open_column();
		rows_done = 0;
		cur_run = '0;
		long_run = '0;
		long_rank = '0;
		prev_rank = '0;
		fresh = 1'b1;
	endfunction

	function automatic void open_frame();
		expanding = 1'b0;
		col = '0;
		sparse_cnt = '0;
		packed_sum = '0;
		wr_idx = '0;
		open_column();
	endfunction

	function automatic void forecast_entry(logic op, logic [15:0] srow, logic [15:0] rk,
			logic [6:0] rl);
		int unsigned len, room, p, limit, i;
		longint unsigned base;
		bit dns;
		rec_t r;
		if (op == OP_SURVEY && expanding) open_frame();
		if (op == OP_EXPAND && !expanding) begin
			expanding = 1'b1;
			col = '0;
			open_column();
		end
		limit = (cfg_preds < MAX_PREDS) ? cfg_preds : MAX_PREDS;
		if (col >= limit) return;
		p = col;
		len = (rl > MAX_CHUNK) ? MAX_CHUNK : rl;
		room = (rows_done < cfg_rows) ? cfg_rows - rows_done : 0;
		if (len > room) len = room;
		r = '0;
		r.col = p[9:0];
		if (op == OP_SURVEY) begin
			if (len != 0) begin
				if (!fresh && rk == prev_rank) cur_run = cur_run + 17'(len);
				else cur_run = 17'(len);
				prev_rank = rk;
				fresh = 1'b0;
				if (cur_run > long_run) begin
					long_run = cur_run;
					long_rank = rk;
				end
				rows_done += len;
			end
			if (rows_done < cfg_rows) return;
			dns = long_run > cfg_thresh;
			dense_mem[p] = dns;
			dom_mem[p] = dns ? long_rank : 16'd0;
			r.kind = KIND_DESC;
			r.rnk = dom_mem[p];
			r.dense = dns;
			r.cnt = dns ? 17'(cfg_rows - long_run) : 17'(cfg_rows);
			r.fin = 1'b1;
			if (dns) begin
				off_mem[p] = packed_sum;
				packed_sum = packed_sum + 27'(cfg_rows - long_run);
			end else begin
				off_mem[p] = 27'(sparse_cnt);
				sparse_cnt = sparse_cnt + 11'd1;
			end
			records_due.push_back(r);
			col = col + 11'd1;
			open_column();
		end else begin
			if (fresh) begin
				base = off_mem[p];
				if (dense_mem[p]) base = base + longint'(sparse_cnt) * cfg_rows;
				else base = base * cfg_rows;
				wr_idx = base[26:0];
				fresh = 1'b0;
			end
			if (!(dense_mem[p] && rk == dom_mem[p])) begin
				for (i = 0; i < len; i++) begin
					r.kind = KIND_ELEM;
					r.row = srow + 16'(i);
					r.rnk = rk;
					r.idx = wr_idx[25:0];
					r.fin = (i + 1 == len);
					records_due.push_back(r);
					wr_idx = wr_idx + 27'd1;
				end
			end
			rows_done += len;
			if (rows_done >= cfg_rows) begin
				col = col + 11'd1;
				open_column();
			end
		end
	endfunction

	task automatic check_field(string tag, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			if (fault_count < 100)
				$display("%0t: %s expected %0h, got %0h", $time, tag, want, got);
			fault_count++;
		end
	endtask

	task automatic push_entry(logic op, logic [15:0] srow, logic [15:0] rk, logic [6:0] len);
		entry_t e;
		e.op = op;
		e.srow = srow;
		e.rk = rk;
		e.len = len;
		runs_to_send.push_back(e);
		entries_queued++;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (runs_to_send.size() != 0 || start || records_due.size() != 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic reconfigure(int unsigned rows, int unsigned preds, int unsigned thr);
		drain();
		write_reg(REG_ROW_COUNT, CFG_W'(rows));
		write_reg(REG_PRED_COUNT, CFG_W'(preds));
		write_reg(REG_DENSE_THRESHOLD, CFG_W'(thr));
	endtask

	// One frame: runs per column, surveyed and then expanded, with occasional
	// truncated passes, altered ranks and stray entries mixed in.
	task automatic queue_frame(int unsigned rows, int unsigned preds);
		entry_t      runs[$];
		entry_t      e;
		logic [15:0] pool [0:2];
		logic [15:0] row_base;
		int unsigned cols, lim, done, step, cut, k, c;
		for (k = 0; k < 3; k++) pool[k] = 16'($urandom);
		row_base = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
		cols = (rows > 300) ? 1 : ((preds < 6) ? preds : 6);
		if (cols == 0) cols = 1;
		for (c = 0; c < cols; c++) begin
			lim = (rows > 300) ? $urandom_range(20, 300) : rows;
			done = 0;
			do begin
				e.op = OP_SURVEY;
				e.rk = ($urandom_range(0, 2) != 0) ? pool[0] : pool[$urandom_range(1, 2)];
				case ($urandom_range(0, 19))
					0: e.len = 7'd0;
					1: e.len = 7'($urandom_range(65, 127));
					2, 3, 4: e.len = 7'($urandom_range(1, 8));
					default: e.len = 7'($urandom_range(1, 64));
				endcase
				if (e.len > lim - done && $urandom_range(0, 3) != 0) e.len = 7'(lim - done);
				e.srow = row_base + 16'(done);
				step = (e.len > MAX_CHUNK) ? MAX_CHUNK : e.len;
				if (step > lim - done) step = lim - done;
				done += step;
				runs.push_back(e);
			end while (done < lim);
		end
		// At least one survey entry keeps every expand pass starting at column 0.
		cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, runs.size()) : runs.size();
		for (k = 0; k < cut; k++) push_entry(OP_SURVEY, runs[k].srow, runs[k].rk, runs[k].len);
		if ($urandom_range(0, 5) == 0)
			push_entry(OP_SURVEY, 16'($urandom), 16'($urandom), 7'($urandom_range(0, 127)));
		cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, runs.size()) : runs.size();
		for (k = 0; k < cut; k++) begin
			e = runs[k];
			if ($urandom_range(0, 9) == 0) e.rk = 16'($urandom);
			push_entry(OP_EXPAND, e.srow, e.rk, e.len);
		end
		if ($urandom_range(0, 5) == 0)
			push_entry(OP_EXPAND, 16'($urandom), 16'($urandom), 7'($urandom_range(0, 127)));
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (wr_en) begin
			case (wr_index)
				REG_ROW_COUNT: cfg_rows = wr_data;
				REG_PRED_COUNT: cfg_preds = wr_data[10:0];
				REG_DENSE_THRESHOLD: cfg_thresh = wr_data;
				default: ;
			endcase
		end
		if (start && busy === 1'b0) forecast_entry(operation, start_row, rank, run_length);
		took <= start && busy === 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && took) begin
				gap_left = fast_mode ? 0 : $urandom_range(0, 12);
				if ($urandom_range(0, 24) == 0) fast_mode = !fast_mode;
			end
			keep_start = start && !took;
			if (!keep_start) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (runs_to_send.size() != 0) begin
					cur = runs_to_send.pop_front();
					operation <= cur.op;
					start_row <= cur.srow;
					rank <= cur.rk;
					run_length <= cur.len;
					keep_start = 1'b1;
				end
			end
			start <= keep_start;
		end
	end

	always @(posedge clk) begin
		rec_t want;
		if (arst_n && strobe === 1'b1) begin
			if (records_due.size() == 0) begin
				if (fault_count < 100)
					$display("%0t: result expected none, got kind %0h predictor %0h row %0h",
						$time, kind, predictor, row_out);
				fault_count++;
			end else begin
				want = records_due.pop_front();
				check_field("kind", want.kind, kind);
				check_field("predictor", want.col, predictor);
				check_field("row_out", want.row, row_out);
				check_field("rank_out", want.rnk, rank_out);
				check_field("out_index", want.idx, out_index);
				check_field("is_dense", want.dense, is_dense);
				check_field("explicit_count", want.cnt, explicit_count);
				check_field("last", want.fin, last);
			end
		end
	end

	initial begin
		int unsigned rows, preds, thr, round_no, k, queued_prev;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		start = 1'b0;
		operation = OP_SURVEY;
		start_row = '0;
		rank = '0;
		run_length = '0;
		cfg_rows = 1;
		cfg_preds = 1;
		cfg_thresh = 17'd65536;
		open_frame();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register values after reset, passes beyond the frame, and pass switching.
		push_entry(OP_SURVEY, 16'hFFFF, 16'hFFFF, 7'h7F);
		push_entry(OP_SURVEY, 16'h0000, 16'h0000, 7'd1);
		push_entry(OP_EXPAND, 16'hFFFF, 16'hFFFF, 7'h7F);
		push_entry(OP_EXPAND, 16'h1234, 16'h0000, 7'd5);
		push_entry(OP_SURVEY, 16'h0000, 16'h0000, 7'd0);
		push_entry(OP_SURVEY, 16'h5555, 16'hAAAA, 7'd64);
		push_entry(OP_EXPAND, 16'hAAAA, 16'h5555, 7'd1);

		// Every column that a later expand can reach gets surveyed once here, so no
		// expand reads an unwritten column.
		reconfigure(1, 8, 0);
		for (k = 0; k < 10; k++)
			push_entry(OP_SURVEY, 16'($urandom), 16'($urandom), 7'($urandom_range(1, 127)));
		for (k = 0; k < 4; k++)
			push_entry(OP_EXPAND, 16'($urandom), 16'($urandom), 7'($urandom_range(0, 127)));

		// One dense column with merged runs, then one sparse column.
		reconfigure(4, 2, 1);
		push_entry(OP_SURVEY, 16'd0, 16'h00A0, 7'd2);
		push_entry(OP_SURVEY, 16'd2, 16'h00A0, 7'd1);
		push_entry(OP_SURVEY, 16'd3, 16'h00B0, 7'd1);
		push_entry(OP_SURVEY, 16'd0, 16'h00C0, 7'd1);
		push_entry(OP_SURVEY, 16'd1, 16'h00D0, 7'd1);
		push_entry(OP_SURVEY, 16'd2, 16'h00C0, 7'd1);
		push_entry(OP_SURVEY, 16'd3, 16'h00D0, 7'd9);
		push_entry(OP_EXPAND, 16'd0, 16'h00A0, 7'd3);
		push_entry(OP_EXPAND, 16'd3, 16'h00B0, 7'd1);
		push_entry(OP_EXPAND, 16'd0, 16'h00C0, 7'd1);
		push_entry(OP_EXPAND, 16'd1, 16'h00D0, 7'd3);

		round_no = 0;
		while (random_sent < 370) begin
			case (round_no)
				0: begin
					rows = 65536;
					preds = 1024;
					thr = 65535;
				end
				1: begin
					rows = 0;
					preds = 3;
					thr = 0;
				end
				2: begin
					rows = 131071;
					preds = 2;
					thr = 131071;
				end
				3: begin
					rows = 10;
					preds = 0;
					thr = 5;
				end
				4: begin
					rows = 1;
					preds = 1;
					thr = 65536;
				end
				default: begin
					rows = ($urandom_range(0, 9) == 0) ? $urandom_range(301, 131071)
						: $urandom_range(1, 160);
					case ($urandom_range(0, 9))
						0: preds = 2047;
						1: preds = 1024;
						default: preds = $urandom_range(1, 6);
					endcase
					case ($urandom_range(0, 5))
						0: thr = 0;
						1: thr = 65536;
						2: thr = rows / 2;
						3: thr = rows - 1;
						4: thr = rows;
						default: thr = $urandom_range(0, rows);
					endcase
				end
			endcase
			reconfigure(rows, preds, thr);
			for (k = $urandom_range(1, 3); k > 0; k--) begin
				queued_prev = entries_queued;
				queue_frame(rows, preds);
				if (preds != 0) random_sent += entries_queued - queued_prev;
			end
			round_no++;
		end

		drain();
		if (fault_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#16_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule

[files.f]
hdl/rrdme_pkg.sv
hdl/rrdme_ctrl.sv
hdl/rrdme_dp.sv
hdl/rle_rank_dense_mode_expander.sv
tb/tb_top.sv
